// ----- hdl/indexed_list_store_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Indexed list store assertion macros
// Shared concurrent assertion forms for the indexed list store unit.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_UNIT_DEFINES_SVH
`define INDEXED_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ILS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ILS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ils_pkg.sv -----
// ---------------------------------------------------------------------------
// Indexed list store package
// Widths, codes and the cell control bundle shared by the list store files.
// ---------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int COUNT_W   = $clog2(CAPACITY + 1);

    localparam int DATA_W    = 32;
    localparam int POS_W     = 10;
    localparam int LEN_W     = 11;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_GET       = 3'd0,
        OP_ADD_HEAD  = 3'd1,
        OP_ADD_TAIL  = 3'd2,
        OP_ADD_INDEX = 3'd3,
        OP_DELETE    = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic              ins;    // open a slot at idx, shift later cells up
        logic              del;    // remove idx, shift later cells down
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- hdl/ils_cell.sv -----
// ---------------------------------------------------------------------------
// Indexed list store cell
// One slot of the list: holds a value, or takes it from a neighbour.
// ---------------------------------------------------------------------------
module ils_cell (
    input  logic                         clk,
    input  ils_pkg::cell_ctrl_t          ctrl,
    input  logic [ils_pkg::IDX_W-1:0]    my_idx,
    input  logic [ils_pkg::DATA_W-1:0]   left_val,
    input  logic [ils_pkg::DATA_W-1:0]   right_val,
    output logic [ils_pkg::DATA_W-1:0]   val,
    output logic [ils_pkg::DATA_W-1:0]   rd_val
);

    logic [ils_pkg::DATA_W-1:0] val_reg;
    logic [ils_pkg::DATA_W-1:0] val_next;
    logic                       above;
    logic                       hit;

    assign above = (my_idx > ctrl.idx);
    assign hit   = (my_idx == ctrl.idx);

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins)
        begin
            if (above)
                val_next = left_val;
            else if (hit)
                val_next = ctrl.value;
        end
        else if (ctrl.del)
        begin
            if (above || hit)
                val_next = right_val;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val    = val_reg;
    assign rd_val = hit ? val_reg : '0;

endmodule

// ----- hdl/ils_chain.sv -----
// ---------------------------------------------------------------------------
// Indexed list store cell row
// Links the cells to their neighbours and gathers the addressed value.
// ---------------------------------------------------------------------------
module ils_chain (
    input  logic                        clk,
    input  ils_pkg::cell_ctrl_t         ctrl,
    output logic [ils_pkg::DATA_W-1:0]  rd_data
);

    logic [ils_pkg::DATA_W-1:0] vals   [ils_pkg::CAPACITY];
    logic [ils_pkg::DATA_W-1:0] masked [ils_pkg::CAPACITY];

    for (genvar k = 0; k < ils_pkg::CAPACITY; k++)
    begin : g_cell
        logic [ils_pkg::DATA_W-1:0] left_val;
        logic [ils_pkg::DATA_W-1:0] right_val;

        if (k == 0)
        begin : g_head
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = vals[k-1];
        end

        if (k == ils_pkg::CAPACITY - 1)
        begin : g_tail
            assign right_val = '0;
        end
        else
        begin : g_mid_r
            assign right_val = vals[k+1];
        end

        ils_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .my_idx    (ils_pkg::IDX_W'(k)),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (vals[k]),
            .rd_val    (masked[k])
        );
    end

    // at most one cell matches the index, so an OR gathers it
    always_comb
    begin
        rd_data = '0;
        for (int k = 0; k < ils_pkg::CAPACITY; k++)
            rd_data = rd_data | masked[k];
    end

endmodule

// ----- hdl/indexed_list_store_unit.sv -----
// ---------------------------------------------------------------------------
// Indexed list store unit
// Ordered list of signed words with get, insert and delete by position.
// ---------------------------------------------------------------------------
// The result of an input transaction is registered in the output register in the next cycle.
// Throughput: one request per cycle while the output is not stalled; each cell shifts or holds per request.
// Input is taken while the output register is empty or being drained.
// Reset: asynchronous, active low; clears the length and the output valid.
// Cell contents are not cleared and are never read before being written.
// ---------------------------------------------------------------------------
`include "indexed_list_store_unit_defines.svh"

module indexed_list_store_unit (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [9:0] position, [41:10] item_value, [47:42] zero
    input  logic [ils_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] opcode
    input  logic [ils_pkg::OP_W-1:0]        s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] read_value, [42:32] length, [47:43] zero
    output logic [ils_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [ils_pkg::ST_W-1:0]        m_axis_tuser
);

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    logic [ils_pkg::COUNT_W-1:0] count_reg;
    logic [ils_pkg::COUNT_W-1:0] count_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    ils_pkg::status_t            status_reg;
    ils_pkg::status_t            status_next;
    logic [ils_pkg::DATA_W-1:0]  read_reg;
    logic [ils_pkg::DATA_W-1:0]  read_next;
    logic [ils_pkg::LEN_W-1:0]   len_reg;
    logic [ils_pkg::LEN_W-1:0]   len_next;

    // -----------------------------------------------------------------------
    // Request decode
    // -----------------------------------------------------------------------
    logic                        in_fire;
    ils_pkg::op_t                op;
    logic [ils_pkg::POS_W-1:0]   position;
    logic [ils_pkg::DATA_W-1:0]  item_value;
    logic [ils_pkg::LEN_W-1:0]   pos_ext;
    logic [ils_pkg::LEN_W-1:0]   cnt_ext;
    logic                        ins_req;
    logic                        ins_ok;
    logic                        del_ok;
    logic                        get_ok;
    logic [ils_pkg::LEN_W-1:0]   ins_pos;
    ils_pkg::status_t            status_c;
    ils_pkg::cell_ctrl_t         ctrl;
    logic [ils_pkg::DATA_W-1:0]  rd_data;

    // Take a new request whenever the output register frees up this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign op         = ils_pkg::op_t'(s_axis_tuser);
    assign position   = s_axis_tdata[ils_pkg::POS_W-1:0];
    assign item_value = s_axis_tdata[ils_pkg::POS_W +: ils_pkg::DATA_W];
    assign pos_ext    = ils_pkg::LEN_W'(position);
    assign cnt_ext    = ils_pkg::LEN_W'(count_reg);

    always_comb
    begin
        ins_req  = 1'b0;
        del_ok   = 1'b0;
        get_ok   = 1'b0;
        ins_pos  = '0;
        status_c = ils_pkg::ST_DONE;
        unique case (op)
            ils_pkg::OP_GET:
            begin
                if (pos_ext < cnt_ext)
                    get_ok = 1'b1;
                else
                    status_c = ils_pkg::ST_RANGE;
            end
            ils_pkg::OP_ADD_HEAD:
            begin
                ins_req = 1'b1;
            end
            ils_pkg::OP_ADD_TAIL:
            begin
                ins_req = 1'b1;
                ins_pos = cnt_ext;
            end
            ils_pkg::OP_ADD_INDEX:
            begin
                // range check takes precedence over the full check
                if (pos_ext > cnt_ext)
                    status_c = ils_pkg::ST_RANGE;
                else
                begin
                    ins_req = 1'b1;
                    ins_pos = pos_ext;
                end
            end
            ils_pkg::OP_DELETE:
            begin
                if (pos_ext < cnt_ext)
                    del_ok = 1'b1;
                else
                    status_c = ils_pkg::ST_RANGE;
            end
            default:
            begin
                // unused opcodes: report done, change nothing
            end
        endcase

        ins_ok = ins_req && (cnt_ext < ils_pkg::LEN_W'(ils_pkg::CAPACITY));
        if (ins_req && !ins_ok)
            status_c = ils_pkg::ST_FULL;
    end

    // Broadcast the shift command to the cell row; only a granted insert or
    // delete moves anything
    always_comb
    begin
        ctrl.ins   = in_fire && ins_ok;
        ctrl.del   = in_fire && del_ok;
        ctrl.idx   = ins_req ? ins_pos[ils_pkg::IDX_W-1:0]
                             : pos_ext[ils_pkg::IDX_W-1:0];
        ctrl.value = item_value;
    end

    ils_chain u_chain (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd_data (rd_data)
    );

    // -----------------------------------------------------------------------
    // Length and result register
    // -----------------------------------------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        read_next      = read_reg;
        len_next       = len_reg;

        if (m_axis_tready)
            out_valid_next = 1'b0;

        if (in_fire)
        begin
            if (ins_ok)
                count_next = count_reg + ils_pkg::COUNT_W'(1);
            else if (del_ok)
                count_next = count_reg - ils_pkg::COUNT_W'(1);

            out_valid_next = 1'b1;
            status_next    = status_c;
            read_next      = get_ok ? rd_data : '0;
            len_next       = ils_pkg::LEN_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: hold while the downstream stalls
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        read_reg   <= read_next;
        len_reg    <= len_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {{(ils_pkg::M_TDATA_W - ils_pkg::LEN_W - ils_pkg::DATA_W){1'b0}},
                            len_reg, read_reg};

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `ILS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= ils_pkg::COUNT_W'(ils_pkg::CAPACITY), "length above capacity")

    `ILS_ASSERT_NEXT(a_ins_grows, clk, rst_n, in_fire && ins_ok,
        count_reg == $past(count_reg) + ils_pkg::COUNT_W'(1), "insert did not grow length")

    `ILS_ASSERT_NOW(a_full_len, clk, rst_n, out_valid_reg && status_reg == ils_pkg::ST_FULL,
        len_reg == ils_pkg::LEN_W'(ils_pkg::CAPACITY), "full status below capacity")

    `ILS_ASSERT_NOW(a_err_no_data, clk, rst_n, out_valid_reg && status_reg != ils_pkg::ST_DONE,
        read_reg == '0, "failed request returned data")

endmodule
